// ===== rtl/core/pad_autorepeat_qualifier_macros.svh =====
// Assertion helpers used by pad_autorepeat_qualifier. Both sample on clk and are disabled in reset.
`ifndef PAD_AUTOREPEAT_QUALIFIER_MACROS_SVH
`define PAD_AUTOREPEAT_QUALIFIER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PAQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/paq_pkg.sv =====
package paq_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DELAY_W = 10;
  localparam int unsigned BTN_W   = 14;
  localparam int unsigned STK_W   = 4;
  localparam int unsigned DZ_W    = 14;
  localparam int unsigned THR_W   = 18;

  localparam logic [DELAY_W-1:0] DELAY_START = 10'd1000;
  localparam logic [DELAY_W-1:0] DELAY_KNEE  = 10'd200;
  localparam logic [DELAY_W-1:0] FLOOR_FAST  = 10'd10;
  localparam logic [DELAY_W-1:0] FLOOR_SLOW  = 10'd80;

  // floor(d * 3 / 5) == (d * 9831) >> 14 for every d below 1024.
  localparam int unsigned        SCALE_SHIFT = 14;
  localparam int unsigned        SCALE_W     = DELAY_W + SCALE_SHIFT;
  localparam logic [SCALE_SHIFT-1:0] SCALE_MUL = 14'd9831;

  localparam logic signed [THR_W-1:0] OFF_Y_FAST = 18'sd2000;
  localparam logic signed [THR_W-1:0] OFF_Y_SLOW = 18'sd5000;
  localparam logic signed [THR_W-1:0] OFF_X_FAST = 18'sd2000;
  localparam logic signed [THR_W-1:0] OFF_X_SLOW = 18'sd15000;

  localparam logic [DZ_W-1:0] DZ_RESET = 14'd7849;

  localparam int unsigned STK_UP    = 0;
  localparam int unsigned STK_DOWN  = 1;
  localparam int unsigned STK_LEFT  = 2;
  localparam int unsigned STK_RIGHT = 3;

  typedef enum logic [2:0] {
    HELD_NONE  = 3'd0,
    HELD_UP    = 3'd1,
    HELD_DOWN  = 3'd2,
    HELD_LEFT  = 3'd3,
    HELD_RIGHT = 3'd4
  } held_code_t;

  typedef enum logic [0:0] {
    CFG_FAST_MENU = 1'b0,
    CFG_DEADZONE  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [BTN_W-1:0] button_flags;
    logic [STK_W-1:0] stick_flags;
    held_code_t       dpad_code;
    held_code_t       stick_code;
  } poll_dec_t;

endpackage

// ===== rtl/core/paq_decode.sv =====
module paq_decode
  import paq_pkg::*;
(
  input  logic                    fast_menu,
  input  logic [DZ_W-1:0]         deadzone,
  input  logic [7:0]              left_trigger,
  input  logic [7:0]              right_trigger,
  input  logic [15:0]             button_word,
  input  logic signed [15:0]      stick_x,
  input  logic signed [15:0]      stick_y,
  output poll_dec_t               dec
);

  logic signed [THR_W-1:0] sx;
  logic signed [THR_W-1:0] sy;
  logic signed [THR_W-1:0] dz;
  logic signed [THR_W-1:0] dz2;
  logic signed [THR_W-1:0] thr_y;
  logic signed [THR_W-1:0] thr_x;
  logic signed [THR_W-1:0] mag_x;
  logic signed [THR_W-1:0] mag_y;
  logic [BTN_W-1:0]        bf;
  logic [STK_W-1:0]        sf;

  assign sx    = THR_W'(stick_x);
  assign sy    = THR_W'(stick_y);
  assign dz    = signed'({{(THR_W-DZ_W){1'b0}}, deadzone});
  assign dz2   = dz + dz;
  assign thr_y = dz + (fast_menu ? OFF_Y_FAST : OFF_Y_SLOW);
  assign thr_x = dz + (fast_menu ? OFF_X_FAST : OFF_X_SLOW);
  assign mag_x = sx[THR_W-1] ? -sx : sx;
  assign mag_y = sy[THR_W-1] ? -sy : sy;

  // Flag order: LT, RT, A, B, X, Y, LB, RB, stick clicks, then d-pad up/down/left/right.
  assign bf = {button_word[3], button_word[2], button_word[1], button_word[0],
               button_word[7], button_word[6], button_word[9], button_word[8],
               button_word[15], button_word[14], button_word[13], button_word[12],
               |right_trigger, |left_trigger};

  always_comb begin
    sf            = '0;
    sf[STK_UP]    = (sy > thr_y) && (mag_x < dz2);
    sf[STK_DOWN]  = (sy < -thr_y) && (mag_x < dz2);
    sf[STK_LEFT]  = (sx < -thr_x) && (mag_y < dz);
    sf[STK_RIGHT] = (sx > thr_x) && (mag_y < dz);
  end

  always_comb begin
    dec.button_flags = bf;
    dec.stick_flags  = sf;
    if (button_word[0]) begin
      dec.dpad_code = HELD_UP;
    end else if (button_word[1]) begin
      dec.dpad_code = HELD_DOWN;
    end else if (button_word[2]) begin
      dec.dpad_code = HELD_LEFT;
    end else if (button_word[3]) begin
      dec.dpad_code = HELD_RIGHT;
    end else begin
      dec.dpad_code = HELD_NONE;
    end
    // The stick code checks right before left.
    if (sf[STK_UP]) begin
      dec.stick_code = HELD_UP;
    end else if (sf[STK_DOWN]) begin
      dec.stick_code = HELD_DOWN;
    end else if (sf[STK_RIGHT]) begin
      dec.stick_code = HELD_RIGHT;
    end else if (sf[STK_LEFT]) begin
      dec.stick_code = HELD_LEFT;
    end else begin
      dec.stick_code = HELD_NONE;
    end
  end

endmodule

// ===== rtl/core/paq_engine.sv =====
module paq_engine
  import paq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              fast_menu,
  input  held_code_t        code,
  input  logic [TIME_W-1:0] now,
  output logic              fire
);

  held_code_t         held_r, held_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic               changed;
  logic [TIME_W-1:0]  elapsed;
  logic [SCALE_W-1:0] scaled;
  logic [DELAY_W-1:0] floor_val;

  assign changed = (code != held_r);
  assign elapsed = now - start_r;
  assign scaled  = SCALE_W'(delay_r) * SCALE_W'(SCALE_MUL);
  assign fire    = step && !changed && (code != HELD_NONE) &&
                   (elapsed > TIME_W'(delay_r));

  always_comb begin
    case (code)
      HELD_LEFT, HELD_RIGHT: floor_val = FLOOR_FAST;
      default:               floor_val = fast_menu ? FLOOR_FAST : FLOOR_SLOW;
    endcase
  end

  always_comb begin
    held_nxt  = held_r;
    start_nxt = start_r;
    delay_nxt = delay_r;
    if (step && changed) begin
      held_nxt  = code;
      start_nxt = (code != HELD_NONE) ? now : '0;
      delay_nxt = DELAY_START;
    end else if (fire) begin
      start_nxt = now;
      delay_nxt = (delay_r > DELAY_KNEE) ? scaled[SCALE_W-1:SCALE_SHIFT] : floor_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= HELD_NONE;
      start_r <= '0;
      delay_r <= DELAY_START;
    end else begin
      held_r  <= held_nxt;
      start_r <= start_nxt;
      delay_r <= delay_nxt;
    end
  end

endmodule

// ===== rtl/core/pad_autorepeat_qualifier.sv =====
// Gamepad poll qualifier with accelerating auto-repeat for d-pad and left stick.
//
// Channels: polls enter on in_valid/in_ready, results leave on out_valid/out_ready,
// and the two registers (fast menu mode, stick deadzone) are written on cfg_valid/
// cfg_ready, which is always ready. Every poll gives exactly one result.
// Path: an accepted poll waits in the input register, then moves to the result register.
// Throughput: one poll per cycle while out_ready is high; the decode and both repeat engines
// give their results combinationally between the input register and the result register.
// A poll with pad_present low updates no state; its result repeats the stored
// flags with result_valid and both repeat bits low.
// Reset (synchronous, active low) empties both registers, clears the held
// directions and flag history, loads both repeat delays with 1000 ms and returns
// the registers to fast mode off and deadzone 7849.
// When the receiver stalls, the result holds, one more poll can wait in the input
// register, and then in_ready drops until the result is taken.
// Configuration is to be written only while no transaction is in flight.
module pad_autorepeat_qualifier
  import paq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  cfg_reg_t             cfg_index,
  input  logic [DZ_W-1:0]      cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_pad_present,
  input  logic [7:0]           in_left_trigger,
  input  logic [7:0]           in_right_trigger,
  input  logic [15:0]          in_button_word,
  input  logic signed [15:0]   in_stick_x,
  input  logic signed [15:0]   in_stick_y,
  input  logic [TIME_W-1:0]    in_now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_result_valid,
  output logic [BTN_W-1:0]     out_button_flags,
  output logic [STK_W-1:0]     out_stick_flags,
  output logic                 out_dpad_repeat,
  output logic                 out_stick_repeat,
  output logic                 out_buttons_steady,
  output logic                 out_stick_steady
);

`include "pad_autorepeat_qualifier_macros.svh"

  logic               fast_menu_r;
  logic [DZ_W-1:0]    deadzone_r;

  logic               s1_valid_r;
  logic               s1_pad_present_r;
  logic [7:0]         s1_left_trigger_r;
  logic [7:0]         s1_right_trigger_r;
  logic [15:0]        s1_button_word_r;
  logic signed [15:0] s1_stick_x_r;
  logic signed [15:0] s1_stick_y_r;
  logic [TIME_W-1:0]  s1_now_r;
  logic               s1_adv;
  logic               step;

  logic [BTN_W-1:0]   prev_buttons_r, prev_buttons_nxt;
  logic [STK_W-1:0]   prev_stick_r, prev_stick_nxt;
  logic [1:0]         steady_r, steady_nxt;

  poll_dec_t          dec;
  logic               dpad_fire;
  logic               stick_fire;

  logic               out_valid_r;
  logic               out_result_valid_r, res_valid_nxt;
  logic [BTN_W-1:0]   out_button_flags_r, res_buttons_nxt;
  logic [STK_W-1:0]   out_stick_flags_r, res_stick_nxt;
  logic               out_dpad_repeat_r, res_drep_nxt;
  logic               out_stick_repeat_r, res_srep_nxt;
  logic               out_buttons_steady_r, res_bst_nxt;
  logic               out_stick_steady_r, res_sst_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_menu_r <= 1'b0;
      deadzone_r  <= DZ_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FAST_MENU: fast_menu_r <= cfg_data[0];
        CFG_DEADZONE:  deadzone_r  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // The input register moves on whenever the result register is free or is being emptied.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign step     = s1_adv && s1_pad_present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pad_present_r   <= in_pad_present;
      s1_left_trigger_r  <= in_left_trigger;
      s1_right_trigger_r <= in_right_trigger;
      s1_button_word_r   <= in_button_word;
      s1_stick_x_r       <= in_stick_x;
      s1_stick_y_r       <= in_stick_y;
      s1_now_r           <= in_now_ms;
    end
  end

  paq_decode u_decode (
    .fast_menu     (fast_menu_r),
    .deadzone      (deadzone_r),
    .left_trigger  (s1_left_trigger_r),
    .right_trigger (s1_right_trigger_r),
    .button_word   (s1_button_word_r),
    .stick_x       (s1_stick_x_r),
    .stick_y       (s1_stick_y_r),
    .dec           (dec)
  );

  paq_engine u_dpad_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .fast_menu (fast_menu_r),
    .code      (dec.dpad_code),
    .now       (s1_now_r),
    .fire      (dpad_fire)
  );

  paq_engine u_stick_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .fast_menu (fast_menu_r),
    .code      (dec.stick_code),
    .now       (s1_now_r),
    .fire      (stick_fire)
  );

  always_comb begin
    res_valid_nxt    = 1'b0;
    res_buttons_nxt  = prev_buttons_r;
    res_stick_nxt    = prev_stick_r;
    res_drep_nxt     = 1'b0;
    res_srep_nxt     = 1'b0;
    res_bst_nxt      = steady_r[0];
    res_sst_nxt      = steady_r[1];
    if (s1_pad_present_r) begin
      res_valid_nxt   = 1'b1;
      res_buttons_nxt = dec.button_flags;
      res_stick_nxt   = dec.stick_flags;
      res_drep_nxt    = dpad_fire;
      res_srep_nxt    = stick_fire;
      res_bst_nxt     = (dec.button_flags == prev_buttons_r) && !dpad_fire;
      res_sst_nxt     = (dec.stick_flags == prev_stick_r) && !stick_fire;
    end
    prev_buttons_nxt = prev_buttons_r;
    prev_stick_nxt   = prev_stick_r;
    steady_nxt       = steady_r;
    if (step) begin
      prev_buttons_nxt = res_buttons_nxt;
      prev_stick_nxt   = res_stick_nxt;
      steady_nxt       = {res_sst_nxt, res_bst_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_buttons_r <= '0;
      prev_stick_r   <= '0;
      steady_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      prev_buttons_r <= prev_buttons_nxt;
      prev_stick_r   <= prev_stick_nxt;
      steady_r       <= steady_nxt;
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_result_valid_r   <= res_valid_nxt;
      out_button_flags_r   <= res_buttons_nxt;
      out_stick_flags_r    <= res_stick_nxt;
      out_dpad_repeat_r    <= res_drep_nxt;
      out_stick_repeat_r   <= res_srep_nxt;
      out_buttons_steady_r <= res_bst_nxt;
      out_stick_steady_r   <= res_sst_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_valid   = out_result_valid_r;
  assign out_button_flags   = out_button_flags_r;
  assign out_stick_flags    = out_stick_flags_r;
  assign out_dpad_repeat    = out_dpad_repeat_r;
  assign out_stick_repeat   = out_stick_repeat_r;
  assign out_buttons_steady = out_buttons_steady_r;
  assign out_stick_steady   = out_stick_steady_r;

  `PAQ_ASSERT_NOW(a_stall_blocks_advance, out_valid_r && !out_ready, !s1_adv, "poll advanced into a stalled result")
  `PAQ_ASSERT_NOW(a_dpad_repeat_qualified, out_valid_r && out_dpad_repeat_r, out_result_valid_r && !out_buttons_steady_r, "d-pad repeat on an invalid or steady result")
  `PAQ_ASSERT_NOW(a_stick_repeat_qualified, out_valid_r && out_stick_repeat_r, out_result_valid_r && !out_stick_steady_r, "stick repeat on an invalid or steady result")
  `PAQ_ASSERT_NEXT(a_absent_pad_quiet, s1_adv && !s1_pad_present_r, !out_result_valid_r && !out_dpad_repeat_r && !out_stick_repeat_r, "absent pad produced a valid or repeating result")

endmodule
